// ----- design/assert_macros.svh -----
// Assertion macros used by the checker module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is asserted
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) else $error("assertion failed");

`endif

// ----- design/xeu_pkg.sv -----
// Types, constants and entity lookup for the XML entity decoder
package xeu_pkg;

  localparam int unsigned QPtrW  = 2;
  localparam int unsigned QDepth = 1 << QPtrW;
  localparam int unsigned QCntW  = QPtrW + 1;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChSemi = 8'h3B;

  localparam logic [2:0] MaxBody = 3'd4;
  localparam int unsigned NumNames = 6;

  localparam logic [31:0] NameBits [NumNames] = '{
    32'h0000_6C74, 32'h0000_6774, 32'h0061_6D70,
    32'h6170_6F73, 32'h7175_6F74, 32'h2378_3230
  };
  localparam logic [2:0] NameLen [NumNames] = '{3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd4};
  localparam logic [7:0] NameChar [NumNames] = '{
    8'h3C, 8'h3E, 8'h26, 8'h27, 8'h22, 8'h20
  };

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_AMP,
    KIND_SEMI
  } byte_kind_e;

  typedef enum logic [1:0] {
    MODE_TEXT,
    MODE_ENTITY,
    MODE_DROP
  } mode_e;

  typedef struct packed {
    byte_kind_e kind;
    logic [7:0] data;
    logic       last;
  } q_item_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] ch;
  } ent_match_t;

  function automatic ent_match_t match_entity(input logic [2:0] cnt,
                                              input logic [31:0] chars);
    ent_match_t r;
    r = '0;
    for (int i = 0; i < NumNames; i++) begin
      if (!r.hit && cnt == NameLen[i] && chars == NameBits[i]) begin
        r.hit = 1'b1;
        r.ch  = NameChar[i];
      end
    end
    return r;
  endfunction

endpackage

// ----- design/xeu_front.sv -----
// Front end: takes input transfers and tags each byte with its kind
module xeu_front import xeu_pkg::*; (
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  input  logic       q_full_i,
  output logic       push_o,
  output q_item_t    item_o
);

  byte_kind_e kind;

  always_comb begin
    if (in_byte_i == ChAmp) begin
      kind = KIND_AMP;
    end else if (in_byte_i == ChSemi) begin
      kind = KIND_SEMI;
    end else begin
      kind = KIND_OTHER;
    end
  end

  assign in_stall_o  = q_full_i;
  assign push_o      = in_valid_i && !q_full_i;
  assign item_o.kind = kind;
  assign item_o.data = in_byte_i;
  assign item_o.last = end_of_string_i;

endmodule

// ----- design/xeu_queue.sv -----
// Small FIFO between the classifier and the decoder
module xeu_queue import xeu_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  q_item_t item_i,
  output logic    full_o,
  input  logic    pop_i,
  output logic    valid_o,
  output q_item_t item_o
);

  q_item_t            mem_q [QDepth];
  logic [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]   cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCntW'(QDepth));
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

// ----- design/xeu_back.sv -----
// Back end: entity state machine and registered result stage
module xeu_back import xeu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       q_valid_i,
  input  q_item_t    q_item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       bad_escape_o,
  output logic       final_result_o
);

  mode_e       mode_q, mode_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] chars_q, chars_d;
  logic        out_valid_q, out_valid_d;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        bad_q, bad_d;
  logic        fin_q, fin_d;

  ent_match_t  hit;
  logic        overlong;
  logic        res_valid;

  // take an item whenever the result register is free or drains this cycle
  assign pop_o    = q_valid_i && (!out_valid_q || !out_stall_i);
  assign hit      = match_entity(cnt_q, chars_q);
  assign overlong = (cnt_q >= MaxBody);

  // next state
  always_comb begin
    mode_d = mode_q;
    if (pop_o) begin
      unique case (mode_q)
        MODE_TEXT: begin
          if (q_item_i.kind == KIND_AMP && !q_item_i.last) begin
            mode_d = MODE_ENTITY;
          end
        end
        MODE_ENTITY: begin
          if (q_item_i.kind == KIND_SEMI) begin
            mode_d = (hit.hit || q_item_i.last) ? MODE_TEXT : MODE_DROP;
          end else if (overlong) begin
            mode_d = q_item_i.last ? MODE_TEXT : MODE_DROP;
          end else if (q_item_i.last) begin
            mode_d = MODE_TEXT;
          end
        end
        MODE_DROP: begin
          if (q_item_i.last) begin
            mode_d = MODE_TEXT;
          end
        end
        default: mode_d = MODE_TEXT;
      endcase
    end
  end

  // results and entity buffer
  always_comb begin
    res_valid  = 1'b0;
    out_byte_d = out_byte_q;
    bad_d      = bad_q;
    fin_d      = fin_q;
    cnt_d      = cnt_q;
    chars_d    = chars_q;
    if (pop_o) begin
      unique case (mode_q)
        MODE_TEXT: begin
          if (q_item_i.kind == KIND_AMP) begin
            cnt_d   = '0;
            chars_d = '0;
            if (q_item_i.last) begin
              res_valid  = 1'b1;
              out_byte_d = '0;
              bad_d      = 1'b1;
              fin_d      = 1'b1;
            end
          end else begin
            res_valid  = 1'b1;
            out_byte_d = q_item_i.data;
            bad_d      = 1'b0;
            fin_d      = q_item_i.last;
          end
        end
        MODE_ENTITY: begin
          if (q_item_i.kind == KIND_SEMI) begin
            res_valid  = 1'b1;
            out_byte_d = hit.hit ? hit.ch : '0;
            bad_d      = !hit.hit;
            fin_d      = hit.hit ? q_item_i.last : 1'b1;
            cnt_d      = '0;
            chars_d    = '0;
          end else if (overlong) begin
            res_valid  = 1'b1;
            out_byte_d = '0;
            bad_d      = 1'b1;
            fin_d      = 1'b1;
            cnt_d      = '0;
            chars_d    = '0;
          end else begin
            cnt_d   = cnt_q + 1'b1;
            chars_d = {chars_q[23:0], q_item_i.data};
            // string ends inside the entity
            if (q_item_i.last) begin
              res_valid  = 1'b1;
              out_byte_d = '0;
              bad_d      = 1'b1;
              fin_d      = 1'b1;
              cnt_d      = '0;
              chars_d    = '0;
            end
          end
        end
        MODE_DROP: begin
          res_valid = 1'b0;
        end
        default: res_valid = 1'b0;
      endcase
    end
    out_valid_d = pop_o ? res_valid : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_TEXT;
      cnt_q       <= '0;
      chars_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      cnt_q       <= cnt_d;
      chars_q     <= chars_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    bad_q      <= bad_d;
    fin_q      <= fin_d;
  end

  assign out_valid_o    = out_valid_q;
  assign out_byte_o     = out_byte_q;
  assign bad_escape_o   = bad_q;
  assign final_result_o = fin_q;

endmodule

// ----- design/xml_entity_unescape.sv -----
// XML entity decoder: one byte per transfer, entities replaced by their character.
// Throughput: one byte per cycle, sustained, with no stall on either side.
// A result is shown the cycle after its byte leaves the four-entry queue; an input byte
// passes through a queue entry and then the result register before it is shown.
// Reset (async, active low) empties the queue, the result stage and the entity state.
module xml_entity_unescape import xeu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] in_byte_i,
  input  logic       end_of_string_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       bad_escape_o,
  output logic       final_result_o
);

  logic    q_full, push, pop, q_valid;
  q_item_t push_item, pop_item;

  xeu_front u_front (
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_byte_i       (in_byte_i),
    .end_of_string_i (end_of_string_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .item_o          (push_item)
  );

  xeu_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .item_o  (pop_item)
  );

  xeu_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_valid_i      (q_valid),
    .q_item_i       (pop_item),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_byte_o     (out_byte_o),
    .bad_escape_o   (bad_escape_o),
    .final_result_o (final_result_o)
  );

endmodule

// ----- design/xeu_checker.sv -----
// Port-level checks for the XML entity decoder
`include "assert_macros.svh"

module xeu_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_stall_o,
  input logic [7:0] in_byte_i,
  input logic       end_of_string_i,
  input logic       out_valid_o,
  input logic       out_stall_i,
  input logic [7:0] out_byte_o,
  input logic       bad_escape_o,
  input logic       final_result_o
);

  // an error always closes the string
  `ASSERT_CLK(a_err_final, out_valid_o && bad_escape_o |-> final_result_o)

  // an error result carries a zero byte
  `ASSERT_CLK(a_err_zero, out_valid_o && bad_escape_o |-> out_byte_o == 8'h00)

  // a stalled result holds
  `ASSERT_CLK(a_out_hold,
              out_valid_o && out_stall_i |=> out_valid_o && $stable(out_byte_o) &&
              $stable(bad_escape_o) && $stable(final_result_o))

  // nothing is offered in the cycle after an edge seen in reset
  `ASSERT_ALWAYS(a_rst_idle, !rst_ni |=> !out_valid_o)

endmodule

bind xml_entity_unescape xeu_checker u_xeu_checker (.*);
